### rtl/mvsm_pkg.sv
// ----------------------------------------------------------------------------
// mvsm_pkg
// Shared types and constants of the multi-voice sample mixer.
// ----------------------------------------------------------------------------
package mvsm_pkg;

  localparam int unsigned Voices      = 16;
  localparam int unsigned SampleWords = 65536;
  localparam int unsigned Sounds      = 64;
  localparam int unsigned VoiceW      = $clog2(Voices);
  localparam int unsigned AddrW       = $clog2(SampleWords);
  localparam int unsigned SoundW      = $clog2(Sounds);
  localparam int unsigned VoiceRecW   = 1 + SoundW + 32 + 16 + 16 + 1;
  localparam int unsigned SoundRecW   = 16 + 17 + 16 + 16;

  typedef enum logic [2:0] {
    ActTick   = 3'd0,
    ActLoad   = 3'd1,
    ActDefine = 3'd2,
    ActPlay   = 3'd3,
    ActStop   = 3'd4,
    ActVolume = 3'd5,
    ActPitch  = 3'd6,
    ActNone   = 3'd7
  } action_e;

  typedef enum logic [3:0] {
    StIdle,
    StScanRd,
    StScanChk,
    StVRd,
    StSRd,
    StW1Rd,
    StW2Rd,
    StMul1,
    StMul2,
    StMul3,
    StAcc,
    StDone
  } state_e;

  typedef struct packed {
    logic              active;
    logic [SoundW-1:0] sound;
    logic [31:0]       position;
    logic [15:0]       volume;
    logic [15:0]       pitch;
    logic              loop;
  } voice_t;

  typedef struct packed {
    logic [15:0] start;
    logic [16:0] length;
    logic [15:0] gain;
    logic [15:0] rate;
  } sound_t;

  function automatic logic signed [16:0] sat_add(logic signed [16:0] acc,
                                                 logic signed [40:0] x);
    logic signed [41:0] s;
    s = 42'(acc) + 42'(x);
    if (s > 42'sd32767) begin
      return 17'sd32767;
    end else if (s < -42'sd32767) begin
      return -17'sd32767;
    end
    return s[16:0];
  endfunction

endpackage

### rtl/mvsm_ram.sv
// ----------------------------------------------------------------------------
// mvsm_ram
// Generic single-port synchronous RAM with registered read.
// ----------------------------------------------------------------------------
module mvsm_ram #(
  parameter int unsigned Width = 32,
  parameter int unsigned Depth = 16
) (
  input  logic                     clk_i,
  input  logic                     we_i,
  input  logic [$clog2(Depth)-1:0] addr_i,
  input  logic [Width-1:0]         wdata_i,
  output logic [Width-1:0]         rdata_o
);

  logic [Width-1:0] mem_q [Depth];

  always_ff @(posedge clk_i) begin
    if (we_i) begin
      mem_q[addr_i] <= wdata_i;
    end
    rdata_o <= mem_q[addr_i];
  end

endmodule

### rtl/multi_voice_sample_mixer_core.sv
// ----------------------------------------------------------------------------
// multi_voice_sample_mixer_core
// Sixteen-voice stereo sample player with linear interpolation and mixing.
// ----------------------------------------------------------------------------
// Load, define and no-op end in StDone; volume and pitch add a voice write-back
// after it; play and stop walk the voice memory, then StVRd; tick walks it and
// takes each active voice through the sound and sample memory reads and the
// three-stage multiply (gain product and step, interpolation, gain scaling).
// One request in flight; busy is high meanwhile; the receiver cannot stall.
// Reset clears the control state and the voice memory via a clearing pass over
// every voice entry, during which busy stays high.
module multi_voice_sample_mixer_core
  import mvsm_pkg::*;
(
  input  logic               clk_i,
  input  logic               rst_ni,
  input  logic               start,
  output logic               busy,
  input  logic [2:0]         action_i,
  input  logic [15:0]        address_i,
  input  logic signed [15:0] left_sample_i,
  input  logic signed [15:0] right_sample_i,
  input  logic [5:0]         sound_id_i,
  input  logic [16:0]        sound_length_i,
  input  logic [15:0]        sound_gain_i,
  input  logic [15:0]        rate_ratio_i,
  input  logic               loop_flag_i,
  input  logic               unique_flag_i,
  input  logic [3:0]         voice_i,
  input  logic [15:0]        value_i,
  output logic               done,
  output logic signed [15:0] left_out_o,
  output logic signed [15:0] right_out_o,
  output logic [3:0]         voice_index_o,
  output logic               voice_found_o
);

  state_e state_q, state_d;
  logic clr_q;
  logic [VoiceW:0] clr_cnt_q;

  action_e act_q;
  logic [AddrW-1:0] addr_q;
  logic [31:0] frame_q;
  logic [SoundW-1:0] snd_q;
  sound_t def_q;
  logic loop_q, uniq_q;
  logic [3:0] vsel_q;
  logic [15:0] value_q;

  logic [VoiceW-1:0] vi_q;
  voice_t vr_q;
  voice_t hv_q;
  sound_t sr_q;
  logic [31:0] w1_q, w2_q;
  logic dup_q, found_q;
  logic [VoiceW-1:0] free_q, hit_q;
  logic hit_ok_q;
  logic signed [16:0] accl_q, accr_q;
  logic signed [16:0] il_q, ir_q;
  logic [31:0] gp_q;
  logic [31:0] step_q;
  logic signed [40:0] cl_q, cr_q;

  logic v_we, s_we, m_we;
  logic [VoiceW-1:0] v_addr;
  voice_t v_wdata, v_rdata;
  logic [SoundW-1:0] s_addr;
  logic [SoundRecW-1:0] s_rdata;
  logic [AddrW-1:0] m_addr;
  logic [31:0] m_rdata;
  sound_t srd;

  // volume/pitch: read in StDone, write back in the following cycle
  logic vp_pend_q;
  voice_t vp_rec;

  assign srd = sound_t'(s_rdata);
  assign s_addr = (act_q == ActTick) ? v_rdata.sound : snd_q;

  mvsm_ram #(.Width(VoiceRecW), .Depth(Voices)) u_voice_ram (
    .clk_i, .we_i(v_we), .addr_i(v_addr), .wdata_i(v_wdata), .rdata_o(v_rdata)
  );
  mvsm_ram #(.Width(SoundRecW), .Depth(Sounds)) u_sound_ram (
    .clk_i, .we_i(s_we), .addr_i(s_addr), .wdata_i(def_q), .rdata_o(s_rdata)
  );
  mvsm_ram #(.Width(32), .Depth(SampleWords)) u_sample_ram (
    .clk_i, .we_i(m_we), .addr_i(m_addr), .wdata_i(frame_q), .rdata_o(m_rdata)
  );

  logic last_v;
  assign last_v = (vi_q == VoiceW'(Voices - 1));

  // interpolation
  logic [16:0] frac, inv;
  logic signed [33:0] il_full, ir_full;
  assign frac = {1'b0, vr_q.position[15:0]};
  assign inv  = 17'd65536 - frac;
  assign il_full = $signed(w1_q[15:0]) * $signed({1'b0, inv})
                 + $signed(w2_q[15:0]) * $signed({1'b0, frac});
  assign ir_full = $signed(w1_q[31:16]) * $signed({1'b0, inv})
                 + $signed(w2_q[31:16]) * $signed({1'b0, frac});

  // end-of-sound test
  logic [33:0] np, lim;
  logic at_end;
  assign np = 34'(vr_q.position) + 34'(step_q) + 34'd65536;
  assign lim = {1'b0, sr_q.length, 16'd0};
  assign at_end = np >= lim;

  always_comb begin
    state_d = state_q;
    case (state_q)
      StIdle: begin
        if (start && !busy) begin
          case (action_e'(action_i))
            ActTick, ActPlay, ActStop: state_d = StScanRd;
            default:                  state_d = StDone;
          endcase
        end
      end
      StScanRd:  state_d = StScanChk;
      StScanChk: begin
        if (act_q == ActTick) begin
          state_d = v_rdata.active ? StSRd : (last_v ? StDone : StScanRd);
        end else begin
          state_d = last_v ? StVRd : StScanRd;
        end
      end
      StVRd:  state_d = StDone;
      StSRd:  state_d = StW1Rd;
      StW1Rd: state_d = StW2Rd;
      StW2Rd: state_d = StMul1;
      StMul1: state_d = StMul2;
      StMul2: state_d = StMul3;
      StMul3: state_d = StAcc;
      StAcc:  state_d = last_v ? StDone : StScanRd;
      StDone: state_d = StIdle;
      default: state_d = StIdle;
    endcase
  end

  logic play_ok;
  assign play_ok = found_q && !(dup_q && uniq_q);

  always_comb begin
    vp_rec = v_rdata;
    if (act_q == ActVolume) vp_rec.volume = value_q;
    else vp_rec.pitch = value_q;
  end

  always_comb begin
    v_we = 1'b0;
    v_addr = vi_q;
    v_wdata = vr_q;
    s_we = 1'b0;
    m_we = 1'b0;
    m_addr = addr_q;
    if (clr_q) begin
      v_we = 1'b1;
      v_addr = clr_cnt_q[VoiceW-1:0];
      v_wdata = '0;
    end else begin
      case (state_q)
        StIdle: begin
          if (vp_pend_q) begin
            v_we = 1'b1;
            v_addr = vsel_q[VoiceW-1:0];
            v_wdata = vp_rec;
          end
        end
        StDone: begin
          s_we = (act_q == ActDefine);
          m_we = (act_q == ActLoad);
          if ((act_q == ActVolume || act_q == ActPitch) && 32'(vsel_q) < Voices) begin
            v_addr = vsel_q[VoiceW-1:0];
          end
        end
        StVRd: begin
          if (act_q == ActPlay) begin
            v_addr = free_q;
            v_we = play_ok;
            v_wdata.active = 1'b1;
            v_wdata.sound = snd_q;
            v_wdata.position = '0;
            v_wdata.loop = loop_q;
            v_wdata.pitch = value_q;
            v_wdata.volume = srd.gain;
          end else begin
            v_addr = hit_q;
            v_we = hit_ok_q;
            v_wdata = hv_q;
            v_wdata.active = 1'b0;
            v_wdata.position = '0;
          end
        end
        StSRd: m_addr = AddrW'(32'(srd.start) + 32'(vr_q.position[31:16]));
        StW1Rd: m_addr = AddrW'(32'(sr_q.start) + 32'(vr_q.position[31:16]) + 32'd1);
        StAcc: begin
          v_we = 1'b1;
          if (at_end) begin
            if (vr_q.loop) v_wdata.position = '0;
            else v_wdata.active = 1'b0;
          end else begin
            v_wdata.position = np[31:0] - 32'd65536;
          end
        end
        default: ;
      endcase
    end
  end

  assign busy = clr_q || (state_q != StIdle) || vp_pend_q;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= StIdle;
      clr_q <= 1'b1;
      clr_cnt_q <= '0;
      done <= 1'b0;
      vp_pend_q <= 1'b0;
    end else begin
      state_q <= state_d;
      done <= 1'b0;
      if (clr_q) begin
        clr_cnt_q <= clr_cnt_q + 1'b1;
        if (clr_cnt_q == (VoiceW + 1)'(Voices - 1)) clr_q <= 1'b0;
      end
      if (state_q == StDone) begin
        if ((act_q == ActVolume || act_q == ActPitch) && 32'(vsel_q) < Voices
            && !vp_pend_q) begin
          vp_pend_q <= 1'b1;
        end else begin
          done <= 1'b1;
        end
      end
      if (vp_pend_q) begin
        vp_pend_q <= 1'b0;
        done <= 1'b1;
      end
    end
  end

  always_ff @(posedge clk_i) begin
    if (start && !busy) begin
      act_q <= action_e'(action_i);
      addr_q <= address_i;
      frame_q <= {right_sample_i, left_sample_i};
      snd_q <= sound_id_i;
      def_q <= '{start: address_i, length: sound_length_i, gain: sound_gain_i,
                 rate: rate_ratio_i};
      loop_q <= loop_flag_i;
      uniq_q <= unique_flag_i;
      vsel_q <= voice_i;
      value_q <= value_i;
      vi_q <= '0;
      accl_q <= '0;
      accr_q <= '0;
      dup_q <= 1'b0;
      found_q <= 1'b0;
      hit_ok_q <= 1'b0;
      free_q <= '0;
      hit_q <= '0;
    end
    case (state_q)
      StScanChk: begin
        vr_q <= v_rdata;
        if (act_q != ActTick) begin
          if (v_rdata.active && v_rdata.sound == snd_q) begin
            dup_q <= 1'b1;
            if (!hit_ok_q) begin
              hit_ok_q <= 1'b1;
              hit_q <= vi_q;
              hv_q <= v_rdata;
            end
          end
          if (!v_rdata.active && !found_q) begin
            found_q <= 1'b1;
            free_q <= vi_q;
          end
          if (!last_v) vi_q <= vi_q + 1'b1;
        end else if (!v_rdata.active && !last_v) begin
          vi_q <= vi_q + 1'b1;
        end
      end
      StSRd:  sr_q <= srd;
      StW1Rd: w1_q <= m_rdata;
      StW2Rd: w2_q <= m_rdata;
      StMul1: begin
        gp_q <= 32'(vr_q.volume) * 32'(sr_q.gain);
        step_q <= (32'(vr_q.pitch) * 32'(sr_q.rate)) >> 10;
      end
      StMul2: begin
        il_q <= 17'(il_full >>> 16);
        ir_q <= 17'(ir_full >>> 16);
      end
      StMul3: begin
        cl_q <= 41'(($signed(49'(il_q)) * $signed({1'b0, gp_q})) >>> 24);
        cr_q <= 41'(($signed(49'(ir_q)) * $signed({1'b0, gp_q})) >>> 24);
      end
      StAcc: begin
        accl_q <= sat_add(accl_q, cl_q);
        accr_q <= sat_add(accr_q, cr_q);
        if (!last_v) vi_q <= vi_q + 1'b1;
      end
      default: ;
    endcase
  end

  always_ff @(posedge clk_i) begin
    if (state_q == StDone || vp_pend_q) begin
      left_out_o <= (act_q == ActTick) ? accl_q[15:0] : 16'sd0;
      right_out_o <= (act_q == ActTick) ? accr_q[15:0] : 16'sd0;
      voice_index_o <= (act_q == ActPlay && play_ok) ? 4'(free_q) : 4'd0;
      voice_found_o <= (act_q == ActPlay) && play_ok;
    end
  end

  assert property (@(posedge clk_i) disable iff (!rst_ni) done |-> busy == 1'b0)
    else $error("done while busy");
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    voice_found_o && done |-> act_q == ActPlay)
    else $error("voice found outside play");
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    clr_q |-> state_q == StIdle)
    else $error("work during clear");

endmodule

### dv/testbench.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// Multi-voice sample mixer testbench
// Loads a wrapped window of sample memory and the whole sound table, then runs
// directed and random requests (tick, load, define, play, stop, volume, pitch,
// no-op). A clocked driver issues requests from a queue with random gaps. A
// voice mixer predictor computes every response. A clocked monitor compares
// each done strobe against the oldest predicted response.
// ----------------------------------------------------------------------------
module testbench;
  import mvsm_pkg::*;

  localparam int CycleLimit = 3000000;

  typedef struct {
    action_e     act;
    logic [15:0] addr;
    logic [15:0] lsmp;
    logic [15:0] rsmp;
    logic [5:0]  snd;
    logic [16:0] len;
    logic [15:0] gain;
    logic [15:0] rate;
    logic        lp;
    logic        uq;
    logic [3:0]  vc;
    logic [15:0] val;
    int          gap;
    bit          drain;
  } req_t;

  typedef struct {
    logic [15:0] left;
    logic [15:0] right;
    logic [3:0]  vidx;
    logic        found;
  } mix_t;

  logic clk_i = 1'b0;
  logic rst_ni = 1'b0;
  logic start = 1'b0;
  logic busy, done;
  logic [2:0] action_i = '0;
  logic [15:0] address_i = '0, left_sample_i = '0, right_sample_i = '0;
  logic [5:0] sound_id_i = '0;
  logic [16:0] sound_length_i = '0;
  logic [15:0] sound_gain_i = '0, rate_ratio_i = '0, value_i = '0;
  logic loop_flag_i = 1'b0, unique_flag_i = 1'b0;
  logic [3:0] voice_i = '0;
  logic signed [15:0] left_out_o, right_out_o;
  logic [3:0] voice_index_o;
  logic voice_found_o;

  multi_voice_sample_mixer_core dut (.*);

  initial begin
    forever #6 clk_i = ~clk_i;
  end

  req_t pending_q[$];
  mix_t mix_q[$];
  int errors = 0;
  int cycles = 0;
  int n_ticks = 0, n_claims = 0, n_reqs = 0;
  bit stim_done = 1'b0;

  // predictor state
  logic [31:0] smem [0:65535];
  logic [15:0] t_start [0:63];
  logic [16:0] t_len   [0:63];
  logic [15:0] t_gain  [0:63];
  logic [15:0] t_rate  [0:63];
  bit          v_act   [0:15];
  logic [5:0]  v_snd   [0:15];
  logic [31:0] v_pos   [0:15];
  logic [15:0] v_vol   [0:15];
  logic [15:0] v_pitch [0:15];
  bit          v_loop  [0:15];

  initial begin
    for (int i = 0; i < 16; i++) begin
      v_act[i] = 0; v_snd[i] = 0; v_pos[i] = 0;
      v_vol[i] = 0; v_pitch[i] = 0; v_loop[i] = 0;
    end
  end

  function automatic longint clamp_add(longint acc, longint x);
    longint s;
    s = acc + x;
    if (s > 32767) s = 32767;
    if (s < -32767) s = -32767;
    return s;
  endfunction

  function automatic mix_t predict_mix(req_t r);
    mix_t m;
    longint lsum, rsum, a, p, l, rr, gp, step, np;
    logic [31:0] w1, w2;
    logic [15:0] base;
    logic [5:0] s;
    bit dup;
    lsum = 0; rsum = 0;
    m.vidx = '0; m.found = 1'b0;
    case (r.act)
      ActTick: begin
        for (int i = 0; i < 16; i++) begin
          if (!v_act[i]) continue;
          s = v_snd[i];
          p = v_pos[i] >> 16;
          a = v_pos[i] & 32'hFFFF;
          base = 16'(t_start[s] + p);
          w1 = smem[base];
          w2 = smem[16'(base + 16'd1)];
          l = (longint'($signed(w1[15:0])) * (65536 - a)
               + longint'($signed(w2[15:0])) * a) >>> 16;
          rr = (longint'($signed(w1[31:16])) * (65536 - a)
                + longint'($signed(w2[31:16])) * a) >>> 16;
          gp = longint'(v_vol[i]) * longint'(t_gain[s]);
          lsum = clamp_add(lsum, (l * gp) >>> 24);
          rsum = clamp_add(rsum, (rr * gp) >>> 24);
          step = (longint'(v_pitch[i]) * longint'(t_rate[s])) >> 10;
          np = longint'(v_pos[i]) + step;
          if (np + 65536 >= (longint'(t_len[s]) << 16)) begin
            if (v_loop[i]) v_pos[i] = 0;
            else v_act[i] = 0;
          end else begin
            v_pos[i] = 32'(np);
          end
        end
      end
      ActLoad: smem[r.addr] = {r.rsmp, r.lsmp};
      ActDefine: begin
        t_start[r.snd] = r.addr; t_len[r.snd] = r.len;
        t_gain[r.snd] = r.gain; t_rate[r.snd] = r.rate;
      end
      ActPlay: begin
        dup = 0;
        for (int i = 0; i < 16; i++) if (v_act[i] && v_snd[i] == r.snd) dup = 1;
        if (!dup || !r.uq) begin
          for (int i = 0; i < 16; i++) begin
            if (!v_act[i]) begin
              v_act[i] = 1; v_snd[i] = r.snd; v_pos[i] = 0; v_loop[i] = r.lp;
              v_pitch[i] = r.val; v_vol[i] = t_gain[r.snd];
              m.vidx = 4'(i); m.found = 1'b1;
              break;
            end
          end
        end
      end
      ActStop: begin
        for (int i = 0; i < 16; i++) begin
          if (v_act[i] && v_snd[i] == r.snd) begin
            v_act[i] = 0; v_pos[i] = 0;
            break;
          end
        end
      end
      ActVolume: v_vol[r.vc] = r.val;
      ActPitch: v_pitch[r.vc] = r.val;
      default: ;
    endcase
    m.left = 16'(lsum);
    m.right = 16'(rsum);
    return m;
  endfunction

  function automatic req_t rand_req(action_e act);
    req_t r;
    r.act = act;
    r.addr = 16'($urandom); r.lsmp = 16'($urandom); r.rsmp = 16'($urandom);
    r.snd = 6'($urandom); r.len = 17'($urandom); r.gain = 16'($urandom);
    r.rate = 16'($urandom); r.lp = 1'($urandom); r.uq = 1'($urandom);
    r.vc = 4'($urandom); r.val = 16'($urandom);
    r.gap = 0; r.drain = 0;
    return r;
  endfunction

  // Sound starts stay in the loaded window; sound 63 never moves (rate 0)
  // so it may carry the longest lengths.
  function automatic req_t define_req(logic [5:0] id);
    req_t r;
    r = rand_req(ActDefine);
    r.snd = id;
    r.addr = 16'hFF00 + 16'($urandom_range(0, 255));
    if (id == 6'd63) begin
      r.rate = '0;
      r.len = ($urandom_range(0, 1)) ? 17'h10000 : 17'($urandom);
    end else begin
      r.len = ($urandom_range(0, 3) == 0) ? 17'($urandom_range(0, 1))
                                          : 17'($urandom_range(0, 200));
    end
    if ($urandom_range(0, 3) == 0) r.gain = 16'($urandom_range(0, 8192));
    return r;
  endfunction

  function automatic int rand_gap();
    int k;
    k = $urandom_range(0, 99);
    if (k < 60) return 0;
    if (k < 92) return $urandom_range(1, 3);
    return $urandom_range(5, 40);
  endfunction

  task automatic push(req_t r);
    pending_q.push_back(r);
  endtask

  // stimulus
  initial begin
    req_t r;
    int k;
    for (int i = 0; i < 512; i++) begin
      r = rand_req(ActLoad);
      r.addr = 16'hFF00 + 16'(i);
      push(r);
    end
    for (int i = 0; i < 64; i++) push(define_req(6'(i)));

    // directed
    r = rand_req(ActLoad); r.addr = 16'hFFFF; r.lsmp = 16'h8000; r.rsmp = 16'h7FFF;
    push(r);
    r = rand_req(ActLoad); r.addr = 16'h0000; r.lsmp = 16'h7FFF; r.rsmp = 16'h8000;
    push(r);
    r = define_req(6'd1); r.addr = 16'hFFFF; r.len = 17'd0; r.gain = 16'hFFFF;
    r.rate = 16'hFFFF; push(r);
    r = define_req(6'd2); r.len = 17'd1; r.gain = 16'd0; push(r);
    r = define_req(6'd63); r.len = 17'h10000; push(r);
    r = rand_req(ActPlay); r.snd = 6'd1; r.uq = 0; r.val = 16'hFFFF; push(r);
    r = rand_req(ActPlay); r.snd = 6'd1; r.uq = 1; push(r);
    r = rand_req(ActPlay); r.snd = 6'd63; r.lp = 1; push(r);
    r = rand_req(ActVolume); r.vc = 4'd15; r.val = 16'hFFFF; push(r);
    r = rand_req(ActPitch); r.vc = 4'd0; r.val = 16'h0000; push(r);
    push(rand_req(ActTick));
    push(rand_req(ActTick));
    r = define_req(6'd63); r.gain = 16'hFFFF; push(r);
    push(rand_req(ActTick));
    for (int i = 0; i < 15; i++) begin
      r = rand_req(ActPlay); r.snd = 6'd63; r.uq = 0; push(r);
    end
    push(rand_req(ActTick));
    r = rand_req(ActStop); r.snd = 6'd40; push(r);
    r = rand_req(ActNone); r.drain = 1; push(r);

    // random
    for (int n = 0; n < 1200; n++) begin
      k = $urandom_range(0, 99);
      if (k < 40) r = rand_req(ActTick);
      else if (k < 60) r = rand_req(ActPlay);
      else if (k < 72) r = rand_req(ActStop);
      else if (k < 79) r = rand_req(ActVolume);
      else if (k < 86) r = rand_req(ActPitch);
      else if (k < 91) r = define_req(6'($urandom));
      else if (k < 97) r = rand_req(ActLoad);
      else r = rand_req(ActNone);
      if (r.act == ActPlay && $urandom_range(0, 1)) r.val = 16'($urandom_range(0, 8192));
      r.gap = ((n / 150) % 3 == 1) ? 0 : rand_gap();
      r.drain = (n % 300 == 299);
      push(r);
    end
    stim_done = 1'b1;
  end

  // reset and driver
  initial begin
    repeat (11) @(posedge clk_i);
    rst_ni <= 1'b1;
  end

  int gap_cnt = 0;
  req_t cur;

  always @(posedge clk_i) begin
    cycles <= cycles + 1;
    if (rst_ni) begin
      if (start && !busy) begin
        mix_q.push_back(predict_mix(cur));
        n_reqs++;
        if (cur.act == ActTick) n_ticks++;
        if (pending_q.size() > 0 && pending_q[0].gap == 0 && !pending_q[0].drain) begin
          cur = pending_q.pop_front();
          action_i <= cur.act; address_i <= cur.addr; left_sample_i <= cur.lsmp;
          right_sample_i <= cur.rsmp; sound_id_i <= cur.snd; sound_length_i <= cur.len;
          sound_gain_i <= cur.gain; rate_ratio_i <= cur.rate; loop_flag_i <= cur.lp;
          unique_flag_i <= cur.uq; voice_i <= cur.vc; value_i <= cur.val;
        end else begin
          start <= 1'b0;
          gap_cnt = (pending_q.size() > 0) ? pending_q[0].gap : 0;
        end
      end else if (!start) begin
        if (gap_cnt > 0) begin
          gap_cnt--;
        end else if (pending_q.size() > 0 && (!pending_q[0].drain || mix_q.size() == 0)) begin
          cur = pending_q.pop_front();
          action_i <= cur.act; address_i <= cur.addr; left_sample_i <= cur.lsmp;
          right_sample_i <= cur.rsmp; sound_id_i <= cur.snd; sound_length_i <= cur.len;
          sound_gain_i <= cur.gain; rate_ratio_i <= cur.rate; loop_flag_i <= cur.lp;
          unique_flag_i <= cur.uq; voice_i <= cur.vc; value_i <= cur.val;
          start <= 1'b1;
        end
      end
    end
  end

  // monitor
  always @(posedge clk_i) begin
    mix_t e;
    if (rst_ni && done) begin
      if (mix_q.size() == 0) begin
        $display("%0t: unexpected response %h %h %0d %0d", $time, left_out_o,
                 right_out_o, voice_index_o, voice_found_o);
        errors++;
      end else begin
        e = mix_q.pop_front();
        if (e.found) n_claims++;
        if (left_out_o !== e.left || right_out_o !== e.right ||
            voice_index_o !== e.vidx || voice_found_o !== e.found) begin
          $display("%0t: expected l=%h r=%h idx=%0d found=%0d, got l=%h r=%h idx=%0d found=%0d",
                   $time, e.left, e.right, e.vidx, e.found, left_out_o, right_out_o,
                   voice_index_o, voice_found_o);
          errors++;
        end
      end
    end
  end

  always @(posedge clk_i) begin
    if (cycles > CycleLimit) begin
      $display("multi_voice_sample_mixer_core: mismatch");
      $finish;
    end
  end

  initial begin
    wait (stim_done);
    while (pending_q.size() > 0 || start || mix_q.size() > 0) @(posedge clk_i);
    repeat (300) @(posedge clk_i);
    if (mix_q.size() > 0) errors++;
    $display("Ran %0d requests, %0d mix ticks, %0d voice claims.", n_reqs, n_ticks, n_claims);
    if (errors == 0) begin
      $display("multi_voice_sample_mixer_core: match");
    end else begin
      $display("multi_voice_sample_mixer_core: mismatch");
    end
    $finish;
  end

endmodule
